### sv/kcl_pkg.sv
// Shared constants and types of the keypad code lock controller.
package kcl_pkg;

  // Default length of the access code in decimal digits.
  localparam int CODE_DIGITS_DEF = 6;

  // Number of BCD digits carried by the code field and shown on the entry output.
  localparam int BCD_DIGITS = 6;

  // Request kinds.
  localparam logic REQ_KEYPAD = 1'b0;
  localparam logic REQ_SENSOR = 1'b1;

  // Largest decimal digit key code and the key codes above the decimal digits.
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DIGIT    = 3'd1,
    EV_DELETED  = 3'd2,
    EV_GRANTED  = 3'd3,
    EV_WRONG    = 3'd4,
    EV_RELOCKED = 3'd5,
    EV_OPEN     = 3'd6
  } kcl_event_t;

  // Lock and door flags travel together between the state registers and the step logic.
  typedef struct packed {
    logic locked;
    logic door_open;
  } kcl_flags_t;

endpackage

### sv/kcl_step.sv
// Next-state and event logic for one keypad or sensor beat.
module kcl_step #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic                                  req_type,
  input  logic [3:0]                            key_code,
  input  logic [23:0]                           valid_code,
  input  logic                                  presence,
  input  kcl_pkg::kcl_flags_t                   flags_cur,
  input  logic [$clog2(CODE_DIGITS + 1) - 1:0]  count_cur,
  input  logic [CODE_DIGITS * 4 - 1:0]          digits_cur,
  output kcl_pkg::kcl_flags_t                   flags_nxt,
  output logic [$clog2(CODE_DIGITS + 1) - 1:0]  count_nxt,
  output logic [CODE_DIGITS * 4 - 1:0]          digits_nxt,
  output kcl_pkg::kcl_event_t                   event_nxt
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int DIG_W = CODE_DIGITS * 4;
  localparam int PAD_W = ((CODE_DIGITS > BCD_DIGITS) ? CODE_DIGITS : BCD_DIGITS) * 4;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_DIGITS);

  logic [PAD_W-1:0] code_pad;
  logic             code_match;

  // Digits are kept newest-first, so position p lines up with code nibble p.
  // Nibbles above the code field read as zero.
  assign code_pad   = PAD_W'(valid_code);
  assign code_match = (count_cur == FULL) && (digits_cur == code_pad[DIG_W-1:0]);

  always_comb begin
    flags_nxt  = flags_cur;
    count_nxt  = count_cur;
    digits_nxt = digits_cur;
    event_nxt  = EV_NONE;
    if (req_type == REQ_KEYPAD) begin
      case (key_code)
        KEY_STAR: begin
          if (count_cur != '0) begin
            count_nxt  = count_cur - CNT_W'(1);
            digits_nxt = digits_cur >> 4;
            event_nxt  = EV_DELETED;
          end
        end
        KEY_HASH: begin
          if (flags_cur.locked) begin
            if (code_match) begin
              flags_nxt.locked = 1'b0;
              event_nxt        = EV_GRANTED;
            end else begin
              event_nxt = EV_WRONG;
            end
          end else begin
            flags_nxt.locked    = 1'b1;
            flags_nxt.door_open = 1'b0;
            event_nxt           = EV_RELOCKED;
          end
          count_nxt  = '0;
          digits_nxt = '0;
        end
        default: begin
          if ((key_code inside {[4'd0:KEY_DIGIT_MAX]}) && flags_cur.locked &&
              (count_cur < FULL)) begin
            count_nxt  = count_cur + CNT_W'(1);
            digits_nxt = DIG_W'(digits_cur << 4) | DIG_W'(key_code);
            event_nxt  = EV_DIGIT;
          end
        end
      endcase
    end else begin
      if (presence && !flags_cur.locked && !flags_cur.door_open) begin
        flags_nxt.door_open = 1'b1;
        event_nxt           = EV_OPEN;
      end
    end
  end

endmodule

### sv/keypad_code_lock_controller_core.sv
// Top level of the keypad code lock controller: input register, step logic, result register.
//
// Each input beat is either a keypad press or a presence-sensor sample and carries the
// currently valid code in BCD, most significant digit first. The block keeps a lock flag,
// a door flag and an entry buffer of up to CODE_DIGITS digits. While locked and not full,
// a digit key appends to the buffer; star deletes the last digit; hash while locked compares
// a full buffer with the code, unlocks on a match and always clears the buffer; hash while
// unlocked relocks, closes the door and clears the buffer. A sensor sample showing presence
// while unlocked and closed opens the door. Every input beat produces exactly one result
// beat reporting the event, both flags, the digit count and the last six entered digits
// right aligned in BCD. An accepted input beat waits in the input register until the result
// register is free; the state update and the result register load then happen together.
// Throughput is one beat per cycle while out_stall does not hold the result; the only limit
// is the lock/door/buffer state, which is updated together with the result register load so
// the next beat in the input register sees it at once. The result register frees itself in
// the same cycle it is taken, so in_stall is raised only while a beat waits in the input
// register and out_stall holds the result.
module keypad_code_lock_controller_core #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_key_code,
  input  logic [23:0] in_valid_code,
  input  logic        in_presence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic        out_locked_now,
  output logic        out_door_now,
  output logic [2:0]  out_entry_count,
  output logic [23:0] out_entry_value
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int DIG_W = CODE_DIGITS * 4;
  localparam int PAD_W = ((CODE_DIGITS > BCD_DIGITS) ? CODE_DIGITS : BCD_DIGITS) * 4;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_DIGITS);

  // Input register.
  logic        s1_valid_r;
  logic        s1_req_type_r;
  logic [3:0]  s1_key_code_r;
  logic [23:0] s1_valid_code_r;
  logic        s1_presence_r;

  // Lock state.
  kcl_flags_t       flags_r;
  kcl_flags_t       flags_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [DIG_W-1:0] digits_r;
  logic [DIG_W-1:0] digits_nxt;
  kcl_event_t       event_nxt;

  // Result register.
  logic             out_valid_r;
  kcl_event_t       out_event_r;
  kcl_flags_t       out_flags_r;
  logic [2:0]       out_count_r;
  logic [23:0]      out_value_r;

  logic             out_free;
  logic             step_fire;
  logic             s1_load;
  logic [CNT_W+2:0] count_ext;
  logic [PAD_W-1:0] digits_pad;

  // The result register can take a new beat when empty or when its beat leaves now.
  assign out_free  = !out_valid_r || !out_stall;
  assign step_fire = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign s1_load   = in_valid && !in_stall;

  kcl_step #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_step (
    .req_type   (s1_req_type_r),
    .key_code   (s1_key_code_r),
    .valid_code (s1_valid_code_r),
    .presence   (s1_presence_r),
    .flags_cur  (flags_r),
    .count_cur  (count_r),
    .digits_cur (digits_r),
    .flags_nxt  (flags_nxt),
    .count_nxt  (count_nxt),
    .digits_nxt (digits_nxt),
    .event_nxt  (event_nxt)
  );

  // The buffer is newest-first with vacated slots zero, so the low six nibbles are
  // already the last six digits, right aligned.
  assign count_ext  = (CNT_W + 3)'(count_nxt);
  assign digits_pad = PAD_W'(digits_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (step_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (s1_load) begin
      s1_req_type_r   <= in_req_type;
      s1_key_code_r   <= in_key_code;
      s1_valid_code_r <= in_valid_code;
      s1_presence_r   <= in_presence;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '{locked: 1'b1, door_open: 1'b0};
      count_r  <= '0;
      digits_r <= '0;
    end else if (step_fire) begin
      flags_r  <= flags_nxt;
      count_r  <= count_nxt;
      digits_r <= digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (step_fire) begin
      out_event_r <= event_nxt;
      out_flags_r <= flags_nxt;
      out_count_r <= count_ext[2:0];
      out_value_r <= digits_pad[23:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_locked_now  = out_flags_r.locked;
  assign out_door_now    = out_flags_r.door_open;
  assign out_entry_count = out_count_r;
  assign out_entry_value = out_value_r;

  // The digit count never runs past the code length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count exceeds code length");

  // The door is only ever open while unlocked.
  a_door_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.door_open |-> !flags_r.locked)
    else $error("door open while locked");

  // Input is held off only while a beat waits in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // A grant leaves the block unlocked with an empty buffer.
  a_grant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == EV_GRANTED) |-> (!out_flags_r.locked && out_count_r == 3'd0))
    else $error("grant result inconsistent");

  // A state update always loads the result register on the next edge.
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> out_valid_r)
    else $error("result lost after state update");

endmodule
